@@ rtl/srb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srb_pkg - shared types of the sequence reorder buffer
// Command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package srb_pkg;

    // Commands from the controller, one strobe per datapath action
    typedef struct packed {
        logic latch_in;    // capture the transfer on the slave side
        logic clr_wr;      // write one slot tag of the clearing pass
        logic calc_offset; // work out the offset from the expected number
        logic calc_addr;   // map the offset to a slot, start the tag lookup
        logic store;       // store the record unless duplicate or out of window
        logic rd_head;     // read the head slot and the one after it
        logic emit_rel;    // load a release into the output register, advance
        logic emit_ack;    // load an acknowledgement into the output register
    } t_dp_cmd;

    // Status back to the controller
    typedef struct packed {
        logic clr_done;     // last slot of the clearing pass is being written
        logic player_match; // incoming transfer is for our own player
        logic head_valid;   // head slot holds the expected record
        logic next_valid;   // slot after the head holds the record after that
        logic last_in;      // captured record ends a request
        logic out_free;     // output register can take a result this cycle
    } t_dp_sts;

endpackage
`default_nettype wire

@@ rtl/sequence_reorder_buffer_unit.sv @@
`default_nettype none
// Sequence: after acceptance the offset, slot lookup, store, head read and check,
//   then one release per in-order record, each after its own head read; an
//   acknowledgement follows the last release, or the check when none is due.
// Input is taken again only once a record has finished its releases and any ack;
//   output stalls hold it up. Another player's record is dropped at once.
// Reset: synchronous, active low; then a slot clearing pass, input held off.
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_unit - per-player resequencing window
// Stores numbered controller records by offset from the expected number,
// releases them in order and acknowledges the end of each request.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer_unit #(
    parameter int WINDOW = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,  // own player
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,   // sequence_number[31:0], axis_value[47:32],
                                             // button_bits[63:48], dpad_bits[71:64]
    input  wire logic [7:0]  s_axis_tuser,   // request_player[7:0]
    input  wire logic        s_axis_tlast,   // last_in_request
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // sequence_number_res[31:0],
                                             // axis_value_res[47:32],
                                             // button_bits_res[63:48],
                                             // dpad_bits_res[71:64]
    output logic [8:0]       m_axis_tuser,   // kind[0], player[8:1]
    output logic             m_axis_tlast    // last
);
    import srb_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    srb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    srb_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (s_axis_tdata),
        .i_in_user     (s_axis_tuser),
        .i_in_last     (s_axis_tlast),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_data    (m_axis_tdata),
        .o_out_user    (m_axis_tuser),
        .o_out_last    (m_axis_tlast)
    );

endmodule
`default_nettype wire

@@ rtl/srb_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srb_ctrl - sequence reorder buffer controller
// Steps each accepted record through lookup, store, release and acknowledge.
// ----------------------------------------------------------------------------
module srb_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire srb_pkg::t_dp_sts i_sts,
    output srb_pkg::t_dp_cmd     o_cmd
);
    import srb_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_OFFS,
        S_ADDR,
        S_LOOK,
        S_RD,
        S_REL,
        S_ACK
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = o_in_ready && i_in_valid;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.latch_in = w_accept;
                // drop records for another player without any result
                if (w_accept && i_sts.player_match) begin
                    n_state = S_OFFS;
                end
            end
            S_OFFS: begin
                o_cmd.calc_offset = 1'b1;
                n_state = S_ADDR;
            end
            S_ADDR: begin
                o_cmd.calc_addr = 1'b1;
                n_state = S_LOOK;
            end
            S_LOOK: begin
                o_cmd.store = 1'b1;
                n_state = S_RD;
            end
            S_RD: begin
                o_cmd.rd_head = 1'b1;
                n_state = S_REL;
            end
            S_REL: begin
                if (!i_sts.head_valid) begin
                    n_state = i_sts.last_in ? S_ACK : S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit_rel = 1'b1;
                    if (i_sts.next_valid) begin
                        n_state = S_RD;
                    end else begin
                        n_state = i_sts.last_in ? S_ACK : S_IDLE;
                    end
                end
            end
            S_ACK: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_ack = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

@@ rtl/srb_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srb_datapath - sequence reorder buffer datapath
// Circular slot window in two memories, expected-number counter, output
// register. Each slot tag holds the number stored there, so a slot counts as
// occupied only while its tag equals the number that currently maps to it.
// ----------------------------------------------------------------------------
module srb_datapath #(
    parameter int WINDOW = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire srb_pkg::t_dp_cmd i_cmd,
    output srb_pkg::t_dp_sts     o_sts,
    input  wire logic            i_cfg_wr_en,
    input  wire logic [7:0]      i_cfg_wr_data,
    input  wire logic [71:0]     i_in_data,   // seq[31:0], axis, buttons, d-pad
    input  wire logic [7:0]      i_in_user,   // request player
    input  wire logic            i_in_last,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output logic [71:0]          o_out_data,  // seq[31:0], axis, buttons, d-pad
    output logic [8:0]           o_out_user,  // kind, player[7:0]
    output logic                 o_out_last
);
    import srb_pkg::*;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);
    localparam logic [IDX_W:0]   WIN_EXT  = (IDX_W + 1)'(WINDOW);
    localparam logic [31:0]      WIN_32   = 32'(WINDOW);

    // Configuration and counters
    logic [7:0]        r_own_player;
    logic [31:0]       r_ne;
    logic [IDX_W-1:0]  r_head;
    logic [IDX_W-1:0]  r_clr_cnt;

    // Captured record
    logic [7:0]        r_req_player;
    logic [31:0]       r_seq;
    logic [39:0]       r_rec;
    logic              r_last_in;

    // Lookup
    logic              r_in_win;
    logic [IDX_W-1:0]  r_off;
    logic [IDX_W-1:0]  r_wr_addr;

    // Memories: tag is {written, number}, record is {axis, buttons, d-pad}
    logic [32:0]       r_tag_mem [WINDOW];
    logic [39:0]       r_rec_mem [WINDOW];
    logic [32:0]       r_tag0;
    logic [32:0]       r_tag1;
    logic [39:0]       r_rd_rec;

    // Output register
    logic              r_m_valid;
    logic [71:0]       r_m_data;
    logic [8:0]        r_m_user;
    logic              r_m_last;

    logic [31:0]       w_offset;
    logic [IDX_W:0]    w_sum;
    logic [IDX_W:0]    w_sum_wrap;
    logic [IDX_W-1:0]  w_slot;
    logic [IDX_W-1:0]  w_head_nx;
    logic [31:0]       w_ne_p1;
    logic              w_hit;
    logic              w_do_store;
    logic              w_tag_we;
    logic [IDX_W-1:0]  w_tag_waddr;
    logic [32:0]       w_tag_wdata;
    logic [IDX_W-1:0]  w_rd0_addr;
    logic              w_out_free;

    // Offset of the record from the expected number, modulo 2^32
    assign w_offset = r_seq - r_ne;

    // Map an offset onto the circular window
    assign w_sum      = {1'b0, r_head} + {1'b0, r_off};
    assign w_sum_wrap = (w_sum >= WIN_EXT) ? (w_sum - WIN_EXT) : w_sum;
    assign w_slot     = w_sum_wrap[IDX_W-1:0];
    assign w_head_nx  = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign w_ne_p1    = r_ne + 32'd1;

    // Store only into an empty slot inside the window
    assign w_hit      = r_tag0[32] && (r_tag0[31:0] == r_seq);
    assign w_do_store = i_cmd.store && r_in_win && !w_hit;

    assign w_tag_we    = i_cmd.clr_wr || w_do_store;
    assign w_tag_waddr = i_cmd.clr_wr ? r_clr_cnt : r_wr_addr;
    assign w_tag_wdata = i_cmd.clr_wr ? 33'd0 : {1'b1, r_seq};
    assign w_rd0_addr  = i_cmd.calc_addr ? w_slot : r_head;

    assign w_out_free = !r_m_valid || i_out_ready;

    // Status
    always_comb begin
        o_sts              = '0;
        o_sts.clr_done     = (r_clr_cnt == LAST_IDX);
        o_sts.player_match = (i_in_user == r_own_player);
        o_sts.head_valid   = r_tag0[32] && (r_tag0[31:0] == r_ne);
        o_sts.next_valid   = r_tag1[32] && (r_tag1[31:0] == w_ne_p1);
        o_sts.last_in      = r_last_in;
        o_sts.out_free     = w_out_free;
    end

    // Tag memory: one write port, two read ports
    always_ff @(posedge i_clk) begin
        if (w_tag_we) begin
            r_tag_mem[w_tag_waddr] <= w_tag_wdata;
        end
        if (i_cmd.calc_addr || i_cmd.rd_head) begin
            r_tag0 <= r_tag_mem[w_rd0_addr];
        end
        if (i_cmd.rd_head) begin
            r_tag1 <= r_tag_mem[w_head_nx];
        end
    end

    // Record memory
    always_ff @(posedge i_clk) begin
        if (w_do_store) begin
            r_rec_mem[r_wr_addr] <= r_rec;
        end
        if (i_cmd.rd_head) begin
            r_rd_rec <= r_rec_mem[r_head];
        end
    end

    // Capture transfer and lookup values
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_req_player <= i_in_user;
            r_seq        <= i_in_data[31:0];
            r_rec        <= {i_in_data[47:32], i_in_data[63:48], i_in_data[71:64]};
            r_last_in    <= i_in_last;
        end
        if (i_cmd.calc_offset) begin
            r_in_win <= (w_offset < WIN_32);
            r_off    <= w_offset[IDX_W-1:0];
        end
        if (i_cmd.calc_addr) begin
            r_wr_addr <= w_slot;
        end
    end

    // Control registers: configuration, window position, clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_player <= 8'd0;
            r_ne         <= 32'd0;
            r_head       <= '0;
            r_clr_cnt    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_own_player <= i_cfg_wr_data;
            end
            if (i_cmd.clr_wr && (r_clr_cnt != LAST_IDX)) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            // advance the window on each release
            if (i_cmd.emit_rel) begin
                r_ne   <= w_ne_p1;
                r_head <= w_head_nx;
            end
        end
    end

    // Output register: hold until transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.emit_rel || i_cmd.emit_ack) begin
            r_m_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_rel) begin
            r_m_data <= {r_rd_rec[7:0], r_rd_rec[23:8], r_rd_rec[39:24], r_ne};
            r_m_user <= {r_own_player, 1'b0};
            r_m_last <= !o_sts.next_valid && !r_last_in;
        end else if (i_cmd.emit_ack) begin
            r_m_data <= {40'd0, r_ne - 32'd1};
            r_m_user <= {r_req_player, 1'b1};
            r_m_last <= 1'b1;
        end
    end

    assign o_out_valid = r_m_valid;
    assign o_out_data  = r_m_data;
    assign o_out_user  = r_m_user;
    assign o_out_last  = r_m_last;

endmodule
`default_nettype wire

@@ dv/sequence_reorder_buffer_unit_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_unit_checker - resequencing scoreboard
// Watches the slave, master and configuration ports of the reorder buffer.
// Keeps its own copy of the window, works out the releases and
// acknowledgements due for every accepted record, and compares each output
// transfer field by field against the oldest one still due.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer_unit_checker #(
    parameter int WINDOW = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,
    input  wire logic        i_s_axis_tvalid,
    input  wire logic        i_s_axis_tready,
    input  wire logic [71:0] i_s_axis_tdata,
    input  wire logic [7:0]  i_s_axis_tuser,
    input  wire logic        i_s_axis_tlast,
    input  wire logic        i_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic [71:0] i_m_axis_tdata,
    input  wire logic [8:0]  i_m_axis_tuser,
    input  wire logic        i_m_axis_tlast,
    output int               o_fail_count,
    output int               o_pending
);

    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [7:0]         player;
        logic [31:0]        seq;
        logic signed [15:0] axis;
        logic [15:0]        buttons;
        logic [7:0]         dpad;
        logic               last;
    } t_srb_result;

    // Shadow of the buffer state
    logic [7:0]        own_player;
    logic [31:0]       next_expected;
    logic [WINDOW-1:0] slot_full;
    logic [39:0]       slot_data [WINDOW];

    t_srb_result pending_results [$];

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    // Store one record and queue every release and acknowledgement it causes
    task automatic resequence_record(input logic [7:0] req_player, input logic [31:0] seq,
                                     input logic [15:0] axis, input logic [15:0] buttons,
                                     input logic [7:0] dpad, input logic last_in);
        logic [31:0] offset;
        t_srb_result held;
        logic        have_held;
        have_held = 1'b0;
        held      = '0;
        if (req_player != own_player) return;

        // drop duplicates and anything outside the window, stale numbers included
        offset = seq - next_expected;
        if (offset < WINDOW && !slot_full[offset]) begin
            slot_full[offset] = 1'b1;
            slot_data[offset] = {axis, buttons, dpad};
        end

        // release the in-order head, shifting the window down each time
        while (slot_full[0]) begin
            if (have_held) pending_results.push_back(held);
            held.kind    = KIND_RELEASE;
            held.player  = own_player;
            held.seq     = next_expected;
            held.axis    = slot_data[0][39:24];
            held.buttons = slot_data[0][23:8];
            held.dpad    = slot_data[0][7:0];
            held.last    = 1'b0;
            have_held    = 1'b1;
            for (int k = 0; k < WINDOW - 1; k++) slot_data[k] = slot_data[k+1];
            slot_full     = slot_full >> 1;
            next_expected = next_expected + 32'd1;
        end

        // acknowledge the end of a request with the highest delivered number
        if (last_in) begin
            if (have_held) pending_results.push_back(held);
            held.kind    = KIND_ACK;
            held.player  = req_player;
            held.seq     = next_expected - 32'd1;
            held.axis    = '0;
            held.buttons = '0;
            held.dpad    = '0;
            held.last    = 1'b0;
            have_held    = 1'b1;
        end

        if (have_held) begin
            held.last = 1'b1;
            pending_results.push_back(held);
        end
    endtask

    task automatic check_transfer(input logic [71:0] data, input logic [8:0] user,
                                  input logic last);
        t_srb_result want;
        if (pending_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected transfer, seq %08h kind %0d",
                                    data[31:0], user[0]));
            return;
        end
        want = pending_results.pop_front();
        if (user[0] !== want.kind)
            flag_mismatch($sformatf("seq %08h kind %0d, want %0d", want.seq, user[0],
                                    want.kind));
        if (user[8:1] !== want.player)
            flag_mismatch($sformatf("seq %08h player %0d, want %0d", want.seq, user[8:1],
                                    want.player));
        if (data[31:0] !== want.seq)
            flag_mismatch($sformatf("seq %08h, want %08h", data[31:0], want.seq));
        if (data[47:32] !== want.axis)
            flag_mismatch($sformatf("seq %08h axis %04h, want %04h", want.seq, data[47:32],
                                    want.axis));
        if (data[63:48] !== want.buttons)
            flag_mismatch($sformatf("seq %08h buttons %04h, want %04h", want.seq,
                                    data[63:48], want.buttons));
        if (data[71:64] !== want.dpad)
            flag_mismatch($sformatf("seq %08h dpad %02h, want %02h", want.seq, data[71:64],
                                    want.dpad));
        if (last !== want.last)
            flag_mismatch($sformatf("seq %08h last %0d, want %0d", want.seq, last,
                                    want.last));
    endtask

    // Sample all channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            own_player    = '0;
            next_expected = '0;
            slot_full     = '0;
            o_fail_count  = 0;
            pending_results.delete();
        end else begin
            if (i_cfg_wr_en) own_player = i_cfg_wr_data;
            if (i_s_axis_tvalid && i_s_axis_tready)
                resequence_record(i_s_axis_tuser, i_s_axis_tdata[31:0],
                                  i_s_axis_tdata[47:32], i_s_axis_tdata[63:48],
                                  i_s_axis_tdata[71:64], i_s_axis_tlast);
            if (i_m_axis_tvalid && i_m_axis_tready)
                check_transfer(i_m_axis_tdata, i_m_axis_tuser, i_m_axis_tlast);
        end
        o_pending = pending_results.size();
    end

endmodule

@@ dv/sequence_reorder_buffer_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_unit_tb - reorder buffer regression
// Drives a directed set of window corner cases, then shuffled bursts of
// numbered records mixed with duplicates, stale numbers, far numbers and
// other players' traffic, under several idling and back-pressure phases and
// player settings. Checking is done by the scoreboard beside the block.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer_unit_tb;

    localparam int WINDOW       = 16;
    localparam int SETTLE       = 64;   // beyond the worst case of one record
    localparam int HOLD_OFF     = 400;
    localparam int PHASE_ITEMS  = 100;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [7:0]  i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [7:0]  s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic [8:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count;
    int pending;

    int          sender_idle_pct = 0;
    int          recv_stall_pct  = 0;
    int          hold_left       = 0;
    bit          hold_request    = 1'b0;
    logic [7:0]  active_player   = '0;
    logic [31:0] stream_next     = '0;
    int          phase_records   = 0;

    sequence_reorder_buffer_unit #(.WINDOW(WINDOW)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    sequence_reorder_buffer_unit_checker #(.WINDOW(WINDOW)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_s_axis_tlast  (s_axis_tlast),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .i_m_axis_tlast  (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_OFF;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one record and hold it until the transfer completes
    task automatic offer_record(input logic [7:0] player, input logic [31:0] seq,
                                input logic [15:0] axis, input logic [15:0] buttons,
                                input logic [7:0] dpad, input logic last_in);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dpad, buttons, axis, seq};
        s_axis_tuser  <= player;
        s_axis_tlast  <= last_in;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (player == active_player) phase_records++;
    endtask

    task automatic offer_random_data(input logic [7:0] player, input logic [31:0] seq,
                                     input logic last_in);
        offer_record(player, seq, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                     8'($urandom_range(255)), last_in);
    endtask

    // Drain everything due, let the block settle, then set the player
    task automatic set_player(input logic [7:0] player);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= player;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        active_player = player;
    endtask

    // One shuffled request with occasional duplicates, stale and far numbers
    // and foreign traffic; or a single noise record
    task automatic run_burst();
        logic [31:0] order [WINDOW];
        logic [31:0] tmp;
        int          n;
        int          pick;
        logic        last_in;
        if ($urandom_range(99) < 15) begin
            offer_random_data(8'($urandom_range(255)), $urandom, 1'($urandom_range(1)));
            return;
        end
        n = ($urandom_range(3) == 0) ? $urandom_range(9, WINDOW) : $urandom_range(1, 8);
        for (int i = 0; i < n; i++) order[i] = stream_next + i;
        for (int i = n - 1; i > 0; i--) begin
            pick        = $urandom_range(i);
            tmp         = order[i];
            order[i]    = order[pick];
            order[pick] = tmp;
        end
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0)
                offer_random_data(active_player + 8'($urandom_range(1, 255)), order[i],
                                  1'($urandom_range(1)));
            if (i > 0 && $urandom_range(7) == 0)
                offer_random_data(active_player, order[$urandom_range(i - 1)],
                                  1'($urandom_range(1)));
            last_in = (i == n - 1) ? ($urandom_range(3) != 0) : ($urandom_range(9) == 0);
            offer_random_data(active_player, order[i], last_in);
            if ($urandom_range(11) == 0)
                offer_random_data(active_player,
                                  ($urandom_range(1) != 0) ?
                                      stream_next - 1 - $urandom_range(40) :
                                      stream_next + n + WINDOW + $urandom_range(100),
                                  1'($urandom_range(1)));
        end
        stream_next = stream_next + n;
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input logic [7:0] player,
                             input bit squeeze);
        set_player(player);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        if (squeeze) hold_request = 1'b1;
        phase_records = 0;
        while (phase_records < PHASE_ITEMS) run_burst();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: acknowledgement before any release, foreign player,
        // duplicate dropped, extremes of data, stale, one past the window,
        // far number, and a full window released in one go
        set_player(8'd0);
        offer_record(8'd0, 32'd1, 16'h1234, 16'h5678, 8'h9a, 1'b1);
        offer_record(8'd1, 32'd0, 16'hffff, 16'hffff, 8'hff, 1'b1);
        offer_record(8'd0, 32'd1, 16'h0bad, 16'h0bad, 8'h0b, 1'b0);
        offer_record(8'd0, 32'd0, 16'h8000, 16'h0000, 8'h00, 1'b1);
        offer_record(8'd0, 32'd3, 16'h0000, 16'h0000, 8'h00, 1'b0);
        offer_record(8'd0, 32'd2, 16'h7fff, 16'hffff, 8'hff, 1'b0);
        offer_record(8'd0, 32'd0, 16'h1111, 16'h2222, 8'h33, 1'b1);
        offer_record(8'd0, 32'd4 + WINDOW, 16'h4444, 16'h5555, 8'h66, 1'b1);
        offer_record(8'd0, 32'hffff_ffff, 16'hffff, 16'hffff, 8'hff, 1'b0);
        for (int i = 5; i < 4 + WINDOW; i++) offer_random_data(8'd0, 32'(i), 1'b0);
        offer_random_data(8'd0, 32'd4, 1'b1);
        stream_next = 4 + WINDOW;

        // Random phases, player extremes among the settings
        run_phase(0, 0, 8'd255, 1'b1);
        run_phase(51, 0, 8'($urandom_range(1, 254)), 1'b0);
        run_phase(0, 51, 8'd0, 1'b0);
        run_phase(7, 7, 8'($urandom_range(1, 254)), 1'b0);

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
